FILE: design/dcsc_pkg.sv
// ----------------------------------------------------------------------------
// dcsc_pkg
// Shared types and constants for the dual channel serial controller.
// ----------------------------------------------------------------------------
package dcsc_pkg;

  typedef enum logic [2:0] {
    OP_READ  = 3'd0,
    OP_WRITE = 3'd1,
    OP_RXCH  = 3'd2,
    OP_TICK  = 3'd3,
    OP_LINE  = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [1:0]  address;
    logic        channel;
    logic [7:0]  data;
    logic        line_select;
    logic        line_level;
    logic [11:0] cpu_cycles;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic       irq_changed;
    logic       tx_valid;
    logic       tx_channel;
    logic [7:0] tx_byte;
  } result_t;

  localparam int ITEM_W   = $bits(item_t);
  localparam int RESULT_W = $bits(result_t);

  localparam logic [3:0] REG_0  = 4'd0;
  localparam logic [3:0] REG_1  = 4'd1;
  localparam logic [3:0] REG_2  = 4'd2;
  localparam logic [3:0] REG_3  = 4'd3;
  localparam logic [3:0] REG_8  = 4'd8;
  localparam logic [3:0] REG_9  = 4'd9;
  localparam logic [3:0] REG_12 = 4'd12;
  localparam logic [3:0] REG_13 = 4'd13;
  localparam logic [3:0] REG_14 = 4'd14;
  localparam logic [3:0] REG_15 = 4'd15;

  localparam logic [2:0] CMD_HIGH  = 3'd1;
  localparam logic [2:0] CMD_RSTEXT = 3'd2;
  localparam logic [2:0] CMD_RSTTX = 3'd5;
  localparam logic [2:0] CMD_RSTHI = 3'd7;

endpackage

FILE: design/dcsc_queue.sv
// ----------------------------------------------------------------------------
// dcsc_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module dcsc_queue
  import dcsc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= ~wr_ptr;
      if (out_valid && out_ready) rd_ptr <= ~rd_ptr;
      count <= count + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

endmodule

FILE: design/dcsc_core.sv
// ----------------------------------------------------------------------------
// dcsc_core
// Back part: register file, receive FIFOs, baud generators and interrupts.
// ----------------------------------------------------------------------------
module dcsc_core
  import dcsc_pkg::*;
#(
  parameter int FIFO_DEPTH  = 16,
  parameter int PCLK_DIVIDE = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  item_t   in_item,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [7:0]    wr_regs [32];
  logic [3:0]    ptr [2];
  logic [7:0]    fifo [2][FIFO_DEPTH];
  logic [PW-1:0] rpos [2];
  logic [PW-1:0] wpos [2];
  logic [CW-1:0] cnt [2];
  logic [1:0] tx_busy, tx_wait, baud_en, zc_seen, ext_p, rx_p, tx_p, cts, dcd;
  logic [17:0] baud_cnt [2];
  logic [16:0] baud_rel [2];
  logic master_en, irq_lvl;

  logic [7:0]    wr_regs_next [32];
  logic [3:0]    ptr_next [2];
  logic [PW-1:0] rpos_next [2];
  logic [PW-1:0] wpos_next [2];
  logic [CW-1:0] cnt_next [2];
  logic [1:0] tx_busy_next, tx_wait_next, baud_en_next, zc_seen_next;
  logic [1:0] ext_p_next, rx_p_next, tx_p_next, cts_next, dcd_next;
  logic [17:0] baud_cnt_next [2];
  logic [16:0] baud_rel_next [2];
  logic master_en_next, irq_lvl_next;

  logic    fifo_we;
  logic    fifo_wch;
  result_t res;
  logic    accept;

  logic        bc;
  logic [3:0]  rsel;
  logic        recomp;
  logic [7:0]  rd;
  logic        sent;
  logic [2:0]  cmd;
  logic [11:0] pdiv;
  logic [17:0] p;
  logic [7:0]  wv;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    wr_regs_next  = wr_regs;
    ptr_next      = ptr;
    rpos_next     = rpos;
    wpos_next     = wpos;
    cnt_next      = cnt;
    tx_busy_next  = tx_busy;
    tx_wait_next  = tx_wait;
    baud_en_next  = baud_en;
    zc_seen_next  = zc_seen;
    ext_p_next    = ext_p;
    rx_p_next     = rx_p;
    tx_p_next     = tx_p;
    cts_next      = cts;
    dcd_next      = dcd;
    baud_cnt_next = baud_cnt;
    baud_rel_next = baud_rel;
    master_en_next = master_en;
    fifo_we  = 1'b0;
    fifo_wch = in_item.channel;
    recomp   = 1'b0;
    rd       = 8'd0;
    sent     = 1'b0;
    bc       = ~in_item.address[1];
    rsel     = 4'd0;
    cmd      = in_item.data[5:3];
    wv       = 8'd0;
    pdiv     = in_item.cpu_cycles / 12'(PCLK_DIVIDE);
    p        = (pdiv == 12'd0) ? 18'd1 : 18'(pdiv);

    unique case (in_item.opcode)
      OP_READ: begin
        if (in_item.address[0]) rsel = REG_8;
        else begin
          rsel = ptr[bc];
          ptr_next[bc] = 4'd0;
        end
        case (rsel)
          REG_0: begin
            if (tx_busy[bc] && tx_wait[bc]) begin
              tx_busy_next[bc] = 1'b0;
              tx_wait_next[bc] = 1'b0;
            end
            rd = {2'b00, cts[bc], 1'b0, dcd[bc],
                  ~(tx_busy[bc] && !tx_wait[bc]), zc_seen[bc], cnt[bc] != '0};
          end
          REG_1: rd = 8'h01;
          REG_2: rd = wr_regs[{bc, REG_2}];
          REG_3: rd = {2'b00, rx_p[0], tx_p[0], ext_p[0], rx_p[1], tx_p[1], ext_p[1]};
          REG_8: begin
            if (cnt[bc] != '0) begin
              rd = fifo[bc][rpos[bc]];
              rpos_next[bc] = (rpos[bc] == PW'(FIFO_DEPTH - 1)) ? '0 : rpos[bc] + PW'(1);
              cnt_next[bc]  = cnt[bc] - CW'(1);
              if (cnt[bc] == CW'(1)) begin
                rx_p_next[bc] = 1'b0;
                recomp = 1'b1;
              end
            end
          end
          REG_12, REG_13, REG_15: rd = wr_regs[{bc, rsel}];
          default: rd = 8'd0;
        endcase
      end
      OP_WRITE: begin
        if (in_item.address[0]) rsel = REG_8;
        else begin
          rsel = ptr[bc];
          if (rsel != REG_0) ptr_next[bc] = 4'd0;
        end
        wv = in_item.data;
        wr_regs_next[{bc, rsel}] = wv;
        case (rsel)
          REG_0: begin
            if (wv[2:0] != 3'd0) ptr_next[bc] = {1'b0, wv[2:0]};
            if (cmd == CMD_HIGH) ptr_next[bc][3] = 1'b1;
            if (cmd == CMD_RSTEXT) begin
              zc_seen_next[bc] = 1'b0;
              ext_p_next[bc] = 1'b0;
              if (baud_en[bc]) baud_cnt_next[bc] = 18'(baud_rel[bc]);
              recomp = 1'b1;
            end else if (cmd == CMD_RSTTX) begin
              tx_p_next[bc] = 1'b0;
              recomp = 1'b1;
            end else if (cmd == CMD_RSTHI) begin
              ext_p_next[bc] = 1'b0;
              tx_p_next[bc] = 1'b0;
              rx_p_next[bc] = (cnt[bc] != '0) && (wr_regs[{bc, REG_1}][4:3] != 2'b00);
              recomp = 1'b1;
            end
          end
          REG_8: begin
            tx_busy_next[bc] = 1'b1;
            tx_wait_next[bc] = 1'b1;
            sent = 1'b1;
          end
          REG_9: master_en_next = wv[3];
          REG_14: begin
            baud_en_next[bc] = wv[0];
            if (wv[0]) begin
              baud_rel_next[bc] = {1'b0, wr_regs[{bc, REG_13}], wr_regs[{bc, REG_12}]}
                                  + 17'd2;
              baud_cnt_next[bc] = 18'(baud_rel_next[bc]);
              zc_seen_next[bc] = 1'b0;
            end
          end
          default: ;
        endcase
      end
      OP_RXCH: begin
        if (cnt[fifo_wch] < CW'(FIFO_DEPTH)) begin
          fifo_we = 1'b1;
          wpos_next[fifo_wch] = (wpos[fifo_wch] == PW'(FIFO_DEPTH - 1)) ? '0
                                : wpos[fifo_wch] + PW'(1);
          cnt_next[fifo_wch]  = cnt[fifo_wch] + CW'(1);
          if (wr_regs[{fifo_wch, REG_1}][4:3] != 2'b00) begin
            rx_p_next[fifo_wch] = 1'b1;
            recomp = 1'b1;
          end
        end
      end
      OP_TICK: begin
        for (int c = 0; c < 2; c++) begin
          if (tx_busy[c] && tx_wait[c]) begin
            tx_busy_next[c] = 1'b0;
            tx_wait_next[c] = 1'b0;
            if (wr_regs[{c[0], REG_1}][1]) tx_p_next[c] = 1'b1;
          end
          if (baud_en[c]) begin
            if (baud_cnt[c] <= p) begin
              zc_seen_next[c] = 1'b1;
              baud_cnt_next[c] = 18'(baud_rel[c]);
              if (wr_regs[{c[0], REG_15}][1]) ext_p_next[c] = 1'b1;
            end else begin
              baud_cnt_next[c] = baud_cnt[c] - p;
            end
          end
        end
        recomp = 1'b1;
      end
      OP_LINE: begin
        if (in_item.line_select) dcd_next[in_item.channel] = in_item.line_level;
        else cts_next[in_item.channel] = in_item.line_level;
      end
      default: ;
    endcase

    irq_lvl_next = recomp ? (master_en_next && |(ext_p_next | rx_p_next | tx_p_next))
                          : irq_lvl;
    res.read_data   = rd;
    res.irq         = irq_lvl_next;
    res.irq_changed = irq_lvl_next != irq_lvl;
    res.tx_valid    = sent;
    res.tx_channel  = sent ? bc : 1'b0;
    res.tx_byte     = sent ? in_item.data : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (accept && fifo_we) fifo[fifo_wch][wpos[fifo_wch]] <= in_item.data;
    if (accept) out_result <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 32; i++) wr_regs[i] <= 8'd0;
      for (int c = 0; c < 2; c++) begin
        ptr[c] <= '0; rpos[c] <= '0; wpos[c] <= '0; cnt[c] <= '0;
        baud_cnt[c] <= '0; baud_rel[c] <= '0;
      end
      tx_busy <= '0; tx_wait <= '0; baud_en <= '0; zc_seen <= '0;
      ext_p <= '0; rx_p <= '0; tx_p <= '0; cts <= '0; dcd <= '0;
      master_en <= 1'b0; irq_lvl <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (accept) begin
        wr_regs <= wr_regs_next; ptr <= ptr_next; rpos <= rpos_next;
        wpos <= wpos_next; cnt <= cnt_next; tx_busy <= tx_busy_next;
        tx_wait <= tx_wait_next; baud_en <= baud_en_next; zc_seen <= zc_seen_next;
        ext_p <= ext_p_next; rx_p <= rx_p_next; tx_p <= tx_p_next;
        cts <= cts_next; dcd <= dcd_next; baud_cnt <= baud_cnt_next;
        baud_rel <= baud_rel_next; master_en <= master_en_next;
        irq_lvl <= irq_lvl_next;
      end
      if (accept) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_count_bound0: assert property (@(posedge clk) disable iff (rst)
    cnt[0] <= CW'(FIFO_DEPTH)) else $error("fifo 0 count overflow");
  a_count_bound1: assert property (@(posedge clk) disable iff (rst)
    cnt[1] <= CW'(FIFO_DEPTH)) else $error("fifo 1 count overflow");
  a_irq_gate: assert property (@(posedge clk) disable iff (rst)
    irq_lvl |-> |(ext_p | rx_p | tx_p) || $past(irq_lvl))
    else $error("irq without pending source");
  a_wait_busy: assert property (@(posedge clk) disable iff (rst)
    (tx_wait & ~tx_busy) == 2'b00) else $error("tx wait without busy");

endmodule

FILE: design/dual_channel_serial_controller.sv
// Each item passes through the queue memory, then the core result register.
// Throughput: one item per cycle while m_tready is high; the register update
// is a single stage.
// A two-entry queue decouples input acceptance from the result stage.
// Reset (rst, synchronous, active high) clears registers, pointers, FIFO
// counts and pending bits; FIFO contents are not cleared.
// ----------------------------------------------------------------------------
// dual_channel_serial_controller
// Top level: input queue in front of the register file core.
// ----------------------------------------------------------------------------
module dual_channel_serial_controller
  import dcsc_pkg::*;
#(
  parameter int FIFO_DEPTH  = 16,
  parameter int PCLK_DIVIDE = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // opcode[2:0], address[4:3], channel[5], data[13:6], line_select[14],
  // line_level[15], cpu_cycles[27:16], zero fill[31:28]
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_data[7:0], irq[8], irq_changed[9], tx_valid[10], tx_channel[11],
  // tx_byte[19:12], zero fill[23:20]
  output logic [23:0] m_tdata
);

  item_t   in_item;
  item_t   q_item;
  logic    q_valid;
  logic    q_ready;
  result_t res;

  assign in_item.opcode      = s_tdata[2:0];
  assign in_item.address     = s_tdata[4:3];
  assign in_item.channel     = s_tdata[5];
  assign in_item.data        = s_tdata[13:6];
  assign in_item.line_select = s_tdata[14];
  assign in_item.line_level  = s_tdata[15];
  assign in_item.cpu_cycles  = s_tdata[27:16];

  dcsc_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
    .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
  );

  dcsc_core #(.FIFO_DEPTH(FIFO_DEPTH), .PCLK_DIVIDE(PCLK_DIVIDE)) u_core (
    .clk(clk), .rst(rst),
    .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_result(res)
  );

  assign m_tdata = {4'd0, res.tx_byte, res.tx_channel, res.tx_valid,
                    res.irq_changed, res.irq, res.read_data};

endmodule
